### rtl/recursive_median_filter_unit_defines.svh
// Assertion helpers for the recursive median filter.
// Checks are active in simulation only. Synthesis sees empty bodies.
`ifndef RECURSIVE_MEDIAN_FILTER_UNIT_DEFINES_SVH
`define RECURSIVE_MEDIAN_FILTER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define RMF_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("rmf: same-cycle check failed");
// Next-cycle implication.
`define RMF_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("rmf: next-cycle check failed");
`else
`define RMF_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons)
`define RMF_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons)
`endif

`endif

### rtl/rmf_pkg.sv
package rmf_pkg;

  localparam int RADIUS      = 2;
  localparam int SAMPLE_BITS = 16;

  localparam int WIN_LEN   = 2 * RADIUS + 1;
  localparam int MAX_RES   = RADIUS + 1;
  localparam int SEEN_W    = $clog2(2 * RADIUS + 1);
  localparam int RIDX_W    = (RADIUS > 1) ? $clog2(RADIUS) : 1;
  localparam int RANK_W    = $clog2(WIN_LEN);
  localparam int CNT_W     = $clog2(MAX_RES + 1);
  localparam int RES_IDX_W = $clog2(MAX_RES);

  // Request queue between front and back; depth is a power of two.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  // Results caused by one input request; the last entry may carry the final mark.
  typedef struct packed {
    logic [MAX_RES-1:0][SAMPLE_BITS-1:0] vals;
    logic [CNT_W-1:0]                    cnt;
    logic                                fin;
  } bundle_t;

endpackage

### rtl/recursive_median_filter_unit.sv
// Channel   Handshake          Fields                     Notes
// -------   ----------------   ------------------------   -----------------------------
// input     push / full        sample_in, end_of_stream   one raw sample per request
// result    pop / empty        sample_out, final_out      0 to RADIUS+1 per input request
//
// An input request is taken when push is high and full is low; a new one can follow
// every cycle while the request queue has room. Results leave at one per cycle from
// the output register while pop is held, so an input that ends a stream holds the
// back end for up to RADIUS+1 results. Synchronous reset clears the sample count and
// the queues. A stall on the result side backs up through the request queue to full.
//
// The front end holds the filter state (pending raw samples, output history,
// sample count) and evaluates the median window in the same cycle it accepts a
// sample, since each median feeds back into the next window. It packs the
// results of one input into a request bundle. The back end unpacks bundles
// one result at a time onto the result ports.
module recursive_median_filter_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  rmf_pkg::sample_t  sample_in,
  input  logic              end_of_stream,
  output logic              empty,
  input  logic              pop,
  output rmf_pkg::sample_t  sample_out,
  output logic              final_out
);
  import rmf_pkg::*;

  logic    accept;
  logic    f_valid;
  bundle_t f_bundle;
  logic    q_valid, q_pop;
  bundle_t q_data;

  // Input request is taken whenever the queue between the halves has room.
  assign accept = push && !full;

  rmf_front u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .sample_in     (sample_in),
    .end_of_stream (end_of_stream),
    .bundle_valid  (f_valid),
    .bundle        (f_bundle)
  );

  // Short request queue decouples filter state updates from result drain.
  rmf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (f_valid),
    .wr_data  (f_bundle),
    .full     (full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_data  (q_data)
  );

  rmf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .empty      (empty),
    .pop        (pop),
    .sample_out (sample_out),
    .final_out  (final_out)
  );

endmodule

### rtl/rmf_front.sv
`include "recursive_median_filter_unit_defines.svh"

module rmf_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  rmf_pkg::sample_t     sample_in,
  input  logic                 end_of_stream,
  output logic                 bundle_valid,
  output rmf_pkg::bundle_t     bundle
);
  import rmf_pkg::*;

  logic [SEEN_W-1:0]                  seen, seen_next;
  logic [RADIUS-1:0][SAMPLE_BITS-1:0] pend, pend_next;
  logic [RADIUS-1:0][SAMPLE_BITS-1:0] hist, hist_next;
  logic [MAX_RES-1:0][SAMPLE_BITS-1:0] ext;
  sample_t                            win [WIN_LEN];
  logic [WIN_LEN-1:0][RANK_W-1:0]     rank;
  sample_t                            med, y;
  logic                               has_y;
  logic [CNT_W-1:0]                   npend;

  // Median by stable ranking: exactly one element has rank RADIUS.
  always_comb begin
    for (int i = 0; i < RADIUS; i++) begin
      win[i]          = hist[i];
      win[RADIUS + i] = pend[i];
    end
    win[2 * RADIUS] = sample_in;
    med = win[0];
    for (int i = 0; i < WIN_LEN; i++) begin
      rank[i] = '0;
      for (int j = 0; j < WIN_LEN; j++) begin
        if (j != i) begin
          if ((win[j] < win[i]) || ((win[j] == win[i]) && (j < i))) begin
            rank[i] = rank[i] + RANK_W'(1);
          end
        end
      end
    end
    for (int i = 0; i < WIN_LEN; i++) begin
      if (rank[i] == RANK_W'(RADIUS)) begin
        med = win[i];
      end
    end
  end

  always_comb begin
    pend_next = pend;
    hist_next = hist;
    seen_next = seen;
    has_y     = 1'b0;
    y         = pend[0];
    if (seen < SEEN_W'(RADIUS)) begin
      pend_next[seen[RIDX_W-1:0]] = sample_in;
    end else begin
      has_y = 1'b1;
      if (seen >= SEEN_W'(2 * RADIUS)) begin
        y = med;
      end
      for (int i = 0; i + 1 < RADIUS; i++) begin
        hist_next[i] = hist[i + 1];
        pend_next[i] = pend[i + 1];
      end
      hist_next[RADIUS-1] = y;
      pend_next[RADIUS-1] = sample_in;
    end
    if (seen < SEEN_W'(2 * RADIUS)) begin
      seen_next = seen + SEEN_W'(1);
    end
    if (seen < SEEN_W'(RADIUS)) begin
      npend = CNT_W'(seen) + CNT_W'(1);
    end else begin
      npend = CNT_W'(RADIUS);
    end
    if (end_of_stream) begin
      seen_next = '0;
    end

    // Pending samples, padded so the slot shift below stays in range.
    for (int k = 0; k < RADIUS; k++) begin
      ext[k] = pend_next[k];
    end
    ext[RADIUS] = '0;

    bundle.vals[0] = has_y ? y : ext[0];
    for (int k = 1; k < MAX_RES; k++) begin
      bundle.vals[k] = has_y ? ext[k-1] : ext[k];
    end
    bundle.cnt = CNT_W'(has_y) + (end_of_stream ? npend : CNT_W'(0));
    bundle.fin = end_of_stream;
    bundle_valid = accept && (bundle.cnt != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
    end else if (accept) begin
      seen <= seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend <= pend_next;
      hist <= hist_next;
    end
  end

  `RMF_ASSERT_IMP(a_seen_bound, clk, rst, 1'b1, seen <= SEEN_W'(2 * RADIUS))
  `RMF_ASSERT_NXT(a_eos_clears, clk, rst, accept && end_of_stream, seen == '0)

endmodule

### rtl/rmf_queue.sv
`include "recursive_median_filter_unit_defines.svh"

module rmf_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  rmf_pkg::bundle_t  wr_data,
  output logic              full,
  input  logic              rd_en,
  output logic              rd_valid,
  output rmf_pkg::bundle_t  rd_data
);
  import rmf_pkg::*;

  bundle_t           ent [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full     = (count == QCNT_W'(QDEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = ent[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      unique case ({wr_en, rd_en})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ent[wr_ptr] <= wr_data;
    end
  end

  `RMF_ASSERT_IMP(a_q_count, clk, rst, 1'b1, count <= QCNT_W'(QDEPTH))

endmodule

### rtl/rmf_back.sv
`include "recursive_median_filter_unit_defines.svh"

module rmf_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  rmf_pkg::bundle_t  q_data,
  output logic              q_pop,
  output logic              empty,
  input  logic              pop,
  output rmf_pkg::sample_t  sample_out,
  output logic              final_out
);
  import rmf_pkg::*;

  bundle_t              cur;
  logic                 cur_valid;
  logic [RES_IDX_W-1:0] idx;
  logic                 last_entry, pop_ok, take;

  always_comb begin
    last_entry = ((CNT_W'(idx) + CNT_W'(1)) == cur.cnt);
    pop_ok     = pop && cur_valid;
    take       = !cur_valid || (pop_ok && last_entry);
    q_pop      = take && q_valid;
    empty      = !cur_valid;
    sample_out = cur.vals[idx];
    final_out  = cur.fin && last_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (take) begin
      cur_valid <= q_valid;
      idx       <= '0;
    end else if (pop_ok) begin
      idx <= idx + RES_IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
  end

  `RMF_ASSERT_IMP(a_idx_in_bundle, clk, rst, cur_valid, CNT_W'(idx) < cur.cnt)

endmodule

### test/tb.sv
`timescale 1ns / 1ps

// Stream-level check of the recursive median filter.
// An initial block queues sample requests (directed streams first, then random
// streams). A clocked driver pushes them, a clocked monitor pops results and
// compares each one against the filter model kept here.
module tb;
  import rmf_pkg::*;

  // One queued input request.
  typedef struct {
    sample_t value;
    logic    eos;
    logic    drain;  // hold this request until every result so far has come out
  } raw_req_t;

  // One predicted result.
  typedef struct {
    sample_t value;
    logic    fin_mark;
  } filt_result_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    push = 1'b0;
  logic    pop = 1'b0;
  sample_t sample_in = '0;
  logic    end_of_stream = 1'b0;
  logic    full;
  logic    empty;
  sample_t sample_out;
  logic    final_out;

  raw_req_t     sample_queue[$];
  filt_result_t expected_out[$];

  // Filter model state: raw samples not yet emitted, last emitted outputs,
  // and how many samples of the current stream have arrived (saturates).
  sample_t raw_hold[RADIUS];
  sample_t out_hist[RADIUS];
  int      seen = 0;

  int       mismatches = 0;
  int       gap_left = 0;
  int       stall_left = 0;
  logic     calm = 1'b0;   // last stretch of the run: no gaps, no stalls
  raw_req_t next_req;

  always #6 clk = ~clk;

  recursive_median_filter_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .sample_in     (sample_in),
    .end_of_stream (end_of_stream),
    .empty         (empty),
    .pop           (pop),
    .sample_out    (sample_out),
    .final_out     (final_out)
  );

  task automatic add_result(sample_t v, logic f);
    filt_result_t r;
    r.value    = v;
    r.fin_mark = f;
    expected_out = {expected_out, r};
  endtask

  // Advance the filter model by one accepted sample and queue what it emits.
  task automatic filter_sample(sample_t x, logic last);
    sample_t win[WIN_LEN];
    sample_t y;
    sample_t key;
    int      i;
    int      j;
    int      npend;
    if (seen < RADIUS) begin
      // stream head: just collect
      raw_hold[seen] = x;
    end else begin
      if (seen >= 2 * RADIUS) begin
        // window: previous outputs, held raw samples, then the new sample
        for (i = 0; i < RADIUS; i++) begin
          win[i]          = out_hist[i];
          win[RADIUS + i] = raw_hold[i];
        end
        win[2 * RADIUS] = x;
        // insertion sort, signed compare
        for (i = 1; i < WIN_LEN; i++) begin
          key = win[i];
          j   = i - 1;
          while (j >= 0 && win[j] > key) begin
            win[j + 1] = win[j];
            j--;
          end
          win[j + 1] = key;
        end
        y = win[WIN_LEN / 2];
      end else begin
        // first RADIUS positions leave raw
        y = raw_hold[0];
      end
      add_result(y, 1'b0);
      for (i = 0; i + 1 < RADIUS; i++) begin
        out_hist[i] = out_hist[i + 1];
        raw_hold[i] = raw_hold[i + 1];
      end
      out_hist[RADIUS - 1] = y;
      raw_hold[RADIUS - 1] = x;
    end
    if (seen < 2 * RADIUS) seen++;
    if (last) begin
      // flush held raw samples; the last one carries the final mark
      npend = (seen < RADIUS) ? seen : RADIUS;
      for (i = 0; i < npend; i++) add_result(raw_hold[i], i == npend - 1);
      seen = 0;
    end
  endtask

  task automatic queue_sample(sample_t v, logic eos, logic drain);
    raw_req_t r;
    r.value = v;
    r.eos   = eos;
    r.drain = drain;
    sample_queue = {sample_queue, r};
  endtask

  // Random sample content; the mode is fixed per stream.
  function automatic sample_t next_value(int mode, sample_t prev);
    sample_t ext[4];
    ext[0] = 16'sh8000;
    ext[1] = 16'sh7fff;
    ext[2] = '0;
    ext[3] = '1;
    case (mode)
      0: return sample_t'($urandom_range(0, 65535));
      1: return sample_t'(int'($urandom_range(0, 16)) - 8);   // many ties
      2: return ext[$urandom_range(0, 3)];
      default: begin
        // slow walk with occasional impulse noise, wraps at the range ends
        if ($urandom_range(0, 5) == 0) return sample_t'($urandom_range(0, 65535));
        return sample_t'(prev + sample_t'(int'($urandom_range(0, 600)) - 300));
      end
    endcase
  endfunction

  // Driver: push requests from sample_queue; hold while full.
  always @(posedge clk) begin
    if (rst) begin
      push     <= 1'b0;
      gap_left = 0;
    end else begin
      if (push && !full) filter_sample(sample_in, end_of_stream);
      if (push && full) begin
        // request not taken yet: keep it on the port
      end else if (gap_left > 0) begin
        gap_left--;
        push <= 1'b0;
      end else if (sample_queue.size() == 0 ||
                   (sample_queue[0].drain && expected_out.size() != 0)) begin
        push <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        gap_left = $urandom_range(1, 12) - 1;
        push <= 1'b0;
      end else begin
        next_req = sample_queue.pop_front();
        push          <= 1'b1;
        sample_in     <= next_req.value;
        end_of_stream <= next_req.eos;
      end
      calm <= sample_queue.size() < 40;
    end
  end

  // Monitor: pop results with random stalls, compare with the oldest prediction.
  always @(posedge clk) begin
    filt_result_t want;
    if (rst) begin
      pop        <= 1'b0;
      stall_left = 0;
    end else begin
      if (pop && !empty) begin
        if (expected_out.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result sample_out=%0d final_out=%0b",
                     $realtime, sample_out, final_out);
        end else begin
          want = expected_out.pop_front();
          if (sample_out !== want.value || final_out !== want.fin_mark) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch sample_out exp %0d got %0d, final_out exp %0b got %0b",
                       $realtime, want.value, sample_out, want.fin_mark, final_out);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 12) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int      total;
    int      len;
    int      mode;
    int      k;
    int      nstream;
    sample_t v;

    // directed: one-sample streams at both extremes
    queue_sample(16'sh7fff, 1'b1, 1'b0);
    queue_sample(16'sh8000, 1'b1, 1'b0);
    // two-sample stream: passes through whole
    queue_sample(16'sh8000, 1'b0, 1'b0);
    queue_sample(16'sh7fff, 1'b1, 1'b0);
    // three and four samples: still shorter than a full window
    queue_sample(16'sh0001, 1'b0, 1'b0);
    queue_sample(16'shffff, 1'b0, 1'b0);
    queue_sample(16'sh0000, 1'b1, 1'b0);
    queue_sample(16'sd100, 1'b0, 1'b0);
    queue_sample(-16'sd100, 1'b0, 1'b0);
    queue_sample(16'sd5, 1'b0, 1'b0);
    queue_sample(-16'sd5, 1'b1, 1'b0);
    // alternating extremes; sent only once the filter has drained
    queue_sample(16'sh7fff, 1'b0, 1'b1);
    queue_sample(16'sh8000, 1'b0, 1'b0);
    queue_sample(16'sh7fff, 1'b0, 1'b0);
    queue_sample(16'sh8000, 1'b0, 1'b0);
    queue_sample(16'sh7fff, 1'b0, 1'b0);
    queue_sample(16'sh0000, 1'b0, 1'b0);
    queue_sample(16'sh8000, 1'b1, 1'b0);
    // ties, impulse and checkerboard bit patterns
    queue_sample(16'shffff, 1'b0, 1'b0);
    queue_sample(16'shffff, 1'b0, 1'b0);
    queue_sample(16'sh7fff, 1'b0, 1'b0);
    queue_sample(16'sh8000, 1'b0, 1'b0);
    queue_sample(16'sh5555, 1'b0, 1'b0);
    queue_sample(16'shaaaa, 1'b1, 1'b0);

    // random streams, mostly long enough to exercise the median path
    total   = sample_queue.size();
    nstream = 0;
    v       = '0;
    while (total < 280) begin
      len  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : $urandom_range(6, 30);
      mode = $urandom_range(0, 3);
      for (k = 0; k < len; k++) begin
        v = next_value(mode, v);
        queue_sample(v, k == len - 1, nstream == 4 && k == 0);
      end
      total += len;
      nstream++;
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (sample_queue.size() != 0 || push || expected_out.size() != 0);
    // keep clocking to catch stray results
    repeat (20) @(posedge clk);

    if (mismatches == 0 && expected_out.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule
